### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the averager core module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/rrca_pkg.sv
// ----------------------------------------------------------------------------
// rrca_pkg
// types and constants of the round-robin channel averager
// ----------------------------------------------------------------------------
package rrca_pkg;

	localparam int SampleWidth = 16;
	localparam int AccWidth    = 32;
	localparam int ChanCount   = 4;
	localparam int ChanWidth   = 2;

	// channel codes
	typedef enum logic [ChanWidth-1:0] {
		CH_CURRENT = 2'd0,
		CH_VOLTAGE = 2'd1,
		CH_POT     = 2'd2,
		CH_TEMP    = 2'd3
	} chan_t;

	// input register contents handed to the update stage
	typedef struct packed {
		logic                   valid;
		logic [SampleWidth-1:0] sample;
	} in_stage_t;

	// fixed measurement order
	function automatic chan_t next_chan(chan_t ch);
		chan_t nxt;
		unique case (ch)
			CH_CURRENT: nxt = CH_VOLTAGE;
			CH_VOLTAGE: nxt = CH_POT;
			CH_POT:     nxt = CH_TEMP;
			CH_TEMP:    nxt = CH_CURRENT;
			default:    nxt = CH_CURRENT;
		endcase
		return nxt;
	endfunction

endpackage

### sv/rrca_input_stage.sv
// ----------------------------------------------------------------------------
// rrca_input_stage
// input register: holds one accepted sample for the update stage
// ----------------------------------------------------------------------------
module rrca_input_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [rrca_pkg::SampleWidth-1:0] sample,
	input  logic                          advance,
	output rrca_pkg::in_stage_t           stage_s1
);

	logic                             valid_s1;
	logic [rrca_pkg::SampleWidth-1:0] sample_s1;

	// free when empty or when the held transaction moves on
	assign sample_ready = !valid_s1 || advance;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	assign stage_s1.valid  = valid_s1;
	assign stage_s1.sample = sample_s1;

endmodule

### sv/rrca_core.sv
// ----------------------------------------------------------------------------
// rrca_core
// accumulator bank, channel pointer, moving-average update and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrca_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rrca_pkg::in_stage_t              stage_s1,
	output logic                             advance,
	output logic                             result_valid,
	input  logic                             result_ready,
	output rrca_pkg::chan_t                  measured_q,
	output rrca_pkg::chan_t                  pointer_q,
	output logic [rrca_pkg::AccWidth-1:0]    acc_q [rrca_pkg::ChanCount]
);

	localparam int HalfWidth = rrca_pkg::AccWidth - rrca_pkg::SampleWidth;

	logic                          res_valid_q;
	logic                          load;
	logic [rrca_pkg::AccWidth-1:0] acc_sel;
	logic [rrca_pkg::AccWidth-1:0] acc_new;
	logic [rrca_pkg::AccWidth-1:0] hi_ext;
	logic [rrca_pkg::AccWidth-1:0] smp_ext;
	logic                          is_signed;

	// result slot free or being drained this cycle
	assign advance = !res_valid_q || result_ready;
	assign load    = stage_s1.valid && advance;

	// acc = acc - (acc >> 16) + sample, signed extension for current
	always_comb begin
		acc_sel   = acc_q[pointer_q];
		is_signed = (pointer_q == rrca_pkg::CH_CURRENT);
		hi_ext    = {{HalfWidth{is_signed && acc_sel[rrca_pkg::AccWidth-1]}},
			acc_sel[rrca_pkg::AccWidth-1 -: rrca_pkg::SampleWidth]};
		smp_ext   = {{HalfWidth{is_signed && stage_s1.sample[rrca_pkg::SampleWidth-1]}},
			stage_s1.sample};
		acc_new   = acc_sel - hi_ext + smp_ext;
	end

	// accumulators and pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rrca_pkg::ChanCount; i++) begin
				acc_q[i] <= '0;
			end
			pointer_q <= rrca_pkg::CH_CURRENT;
		end else if (load) begin
			acc_q[pointer_q] <= acc_new;
			pointer_q        <= rrca_pkg::next_chan(pointer_q);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= stage_s1.valid;
		end
	end

	// channel just credited
	always_ff @(posedge clk) begin
		if (load) begin
			measured_q <= pointer_q;
		end
	end

	assign result_valid = res_valid_q;

	`ASSERT_IMPL(a_next_follows, clk, arst_n, res_valid_q,
		pointer_q == rrca_pkg::next_chan(measured_q))
	`ASSERT_NEXT(a_stall_holds_state, clk, arst_n, res_valid_q && !result_ready,
		res_valid_q && $stable(pointer_q) && $stable(acc_q[measured_q]))
	`ASSERT_NEXT(a_load_sets_valid, clk, arst_n, load, res_valid_q)

endmodule

### sv/round_robin_adc_channel_averager_unit.sv
// ----------------------------------------------------------------------------
// round_robin_adc_channel_averager_unit
// four-channel exponential moving average over a fixed conversion order
// ----------------------------------------------------------------------------
// Usage: each sample transaction (sample_valid/sample_ready) carries one
// conversion word, credited to the channel now measured, in the order
// current, bus voltage, potentiometer, temperature, then current again.
// Each channel keeps a 32-bit accumulator updated as acc - (acc >> 16) + sample;
// the current channel uses signed values. One result transaction
// (result_valid/result_ready) follows each sample: the channel credited, its
// new average, the next channel and all four averages after the update.
// A sample passes the input register, then the single accumulator
// add/subtract into the result register. Throughput is one sample per
// cycle while the receiver takes results, set by that one update path.
// While the receiver stalls, the held result stays put and one more
// sample can wait in the input register before sample_ready drops.
// Reset clears all accumulators to zero and points at the current channel.
// ----------------------------------------------------------------------------
module round_robin_adc_channel_averager_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic [15:0]        sample,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         measured_channel,
	output logic [15:0]        filtered_value,
	output logic [1:0]         next_channel,
	output logic signed [15:0] current_average,
	output logic [15:0]        voltage_average,
	output logic [15:0]        pot_average,
	output logic [15:0]        temperature_average
);

	localparam int Aw = rrca_pkg::AccWidth;
	localparam int Sw = rrca_pkg::SampleWidth;

	rrca_pkg::in_stage_t stage_s1;
	logic                advance;
	rrca_pkg::chan_t     measured_q;
	rrca_pkg::chan_t     pointer_q;
	logic [Aw-1:0]       acc_q [rrca_pkg::ChanCount];
	logic [Aw-1:0]       acc_meas;

	// input register
	rrca_input_stage u_input (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.advance      (advance),
		.stage_s1     (stage_s1)
	);

	// update and result stage
	rrca_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_s1     (stage_s1),
		.advance      (advance),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.measured_q   (measured_q),
		.pointer_q    (pointer_q),
		.acc_q        (acc_q)
	);

	// result fields read from the state, which holds while a result waits
	assign acc_meas            = acc_q[measured_q];
	assign measured_channel    = measured_q;
	assign next_channel        = pointer_q;
	assign filtered_value      = acc_meas[Aw-1 -: Sw];
	assign current_average     = $signed(acc_q[rrca_pkg::CH_CURRENT][Aw-1 -: Sw]);
	assign voltage_average     = acc_q[rrca_pkg::CH_VOLTAGE][Aw-1 -: Sw];
	assign pot_average         = acc_q[rrca_pkg::CH_POT][Aw-1 -: Sw];
	assign temperature_average = acc_q[rrca_pkg::CH_TEMP][Aw-1 -: Sw];

endmodule
